### design/e8b10b_pkg.sv
// Shared types, code tables and helper functions for the 8b/10b packer.
package e8b10b_pkg;

  localparam int SYM_W    = 10;
  localparam int BYTE_W   = 8;
  localparam int GROUP_W  = 4 * SYM_W;
  localparam int HOLD_W   = 3 * SYM_W;
  localparam int BYTES_PER_GROUP = GROUP_W / BYTE_W;
  localparam int IDX_W    = $clog2(BYTES_PER_GROUP);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BYTES_PER_GROUP - 1);
  localparam logic [1:0]       HELD_FULL = 2'd3;

  localparam logic [4:0] X_D07  = 5'd7;
  localparam logic [4:0] X_D11  = 5'd11;
  localparam logic [4:0] X_D13  = 5'd13;
  localparam logic [4:0] X_D14  = 5'd14;
  localparam logic [4:0] X_D17  = 5'd17;
  localparam logic [4:0] X_D18  = 5'd18;
  localparam logic [4:0] X_D20  = 5'd20;
  localparam logic [2:0] Y_P7   = 3'd7;
  localparam logic [3:0] Y_D3   = 4'd3;
  localparam logic [3:0] Y_A7   = 4'd8;

  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [SYM_W-1:0]   symbol_t;

  function automatic logic [5:0] six_neg(input logic [4:0] x);
    logic [5:0] c;
    unique case (x)
      5'd0:  c = 6'h27;  5'd1:  c = 6'h1D;  5'd2:  c = 6'h2D;  5'd3:  c = 6'h31;
      5'd4:  c = 6'h35;  5'd5:  c = 6'h29;  5'd6:  c = 6'h19;  5'd7:  c = 6'h38;
      5'd8:  c = 6'h39;  5'd9:  c = 6'h25;  5'd10: c = 6'h15;  5'd11: c = 6'h34;
      5'd12: c = 6'h0D;  5'd13: c = 6'h2C;  5'd14: c = 6'h1C;  5'd15: c = 6'h17;
      5'd16: c = 6'h1B;  5'd17: c = 6'h23;  5'd18: c = 6'h13;  5'd19: c = 6'h32;
      5'd20: c = 6'h0B;  5'd21: c = 6'h2A;  5'd22: c = 6'h1A;  5'd23: c = 6'h3A;
      5'd24: c = 6'h33;  5'd25: c = 6'h26;  5'd26: c = 6'h16;  5'd27: c = 6'h36;
      5'd28: c = 6'h0E;  5'd29: c = 6'h2E;  5'd30: c = 6'h1E;  5'd31: c = 6'h2B;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] four_neg(input logic [3:0] y);
    logic [3:0] c;
    unique case (y)
      4'd0: c = 4'hB;  4'd1: c = 4'h9;  4'd2: c = 4'h5;  4'd3: c = 4'hC;
      4'd4: c = 4'hD;  4'd5: c = 4'hA;  4'd6: c = 4'h6;  4'd7: c = 4'hE;
      4'd8: c = 4'h7;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ones6(input logic [5:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 6; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [2:0] ones4(input logic [3:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

endpackage

### design/e8b10b_front.sv
// Front end: encodes each byte to a 10-bit symbol and packs four into a group.
module e8b10b_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic [0:0]            in_tuser,
  output logic                  grp_valid,
  input  logic                  grp_ready,
  output e8b10b_pkg::group_t    grp_data
);
  import e8b10b_pkg::*;

  logic              rd_r, rd_nxt;
  logic [HOLD_W-1:0] shift_r, shift_nxt;
  logic [1:0]        held_r, held_nxt;

  logic              acc;
  logic              rd_in, rd_mid, rd_out;
  logic [HOLD_W-1:0] shift_in;
  logic [1:0]        held_in;
  logic [4:0]        x;
  logic [2:0]        y;
  logic [3:0]        y_sel;
  logic [5:0]        six;
  logic [3:0]        four;
  logic [2:0]        n6, n4;
  symbol_t           sym;

  assign in_tready = grp_ready;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    rd_in    = in_tuser[0] ? 1'b0 : rd_r;
    shift_in = in_tuser[0] ? '0 : shift_r;
    held_in  = in_tuser[0] ? '0 : held_r;
    x        = in_tdata[4:0];
    y        = in_tdata[7:5];

    six = six_neg(x);
    if (rd_in && (ones6(six) != 3'd3 || x == X_D07)) begin
      six = ~six;
    end
    n6 = ones6(six);
    if (n6 > 3'd3) begin
      rd_mid = 1'b1;
    end else if (n6 < 3'd3) begin
      rd_mid = 1'b0;
    end else begin
      rd_mid = rd_in;
    end

    y_sel = {1'b0, y};
    if (y == Y_P7 &&
        ((!rd_mid && (x == X_D17 || x == X_D18 || x == X_D20)) ||
         (rd_mid && (x == X_D11 || x == X_D13 || x == X_D14)))) begin
      y_sel = Y_A7;
    end
    four = four_neg(y_sel);
    if (rd_mid && (ones4(four) != 3'd2 || y_sel == Y_D3)) begin
      four = ~four;
    end
    n4 = ones4(four);
    if (n4 > 3'd2) begin
      rd_out = 1'b1;
    end else if (n4 < 3'd2) begin
      rd_out = 1'b0;
    end else begin
      rd_out = rd_mid;
    end
    sym = {six, four};

    grp_valid = acc && (held_in == HELD_FULL);
    grp_data  = {shift_in, sym};

    rd_nxt    = rd_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    if (acc) begin
      rd_nxt = rd_out;
      if (held_in == HELD_FULL) begin
        shift_nxt = '0;
        held_nxt  = '0;
      end else begin
        shift_nxt = {shift_in[HOLD_W-SYM_W-1:0], sym};
        held_nxt  = held_in + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r    <= 1'b0;
      shift_r <= '0;
      held_r  <= '0;
    end else begin
      rd_r    <= rd_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
    end
  end

  a_group_clears: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid |=> (held_r == 2'd0 && shift_r == '0))
    else $error("packer did not clear after a full group");

  a_push_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser[0] && held_r == HELD_FULL) |-> grp_valid)
    else $error("fourth symbol did not emit a group");

endmodule

### design/e8b10b_fifo.sv
// Two-entry queue of packed groups between the front and back ends.
module e8b10b_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  e8b10b_pkg::group_t    push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output e8b10b_pkg::group_t    pop_data
);
  import e8b10b_pkg::*;

  group_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count out of range");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

### design/e8b10b_back.sv
// Back end: sends each 40-bit group as five bytes, most significant first.
module e8b10b_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  e8b10b_pkg::group_t    q_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);
  import e8b10b_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  group_t           group_r, group_nxt;

  assign out_tvalid = busy_r;
  assign out_tdata  = group_r[GROUP_W-1 -: BYTE_W];
  assign out_tlast  = (idx_r == LAST_IDX);
  assign q_ready    = !busy_r || (out_tready && out_tlast);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    group_nxt = group_r;
    if (q_ready) begin
      busy_nxt  = q_valid;
      idx_nxt   = '0;
      group_nxt = q_data;
    end else if (out_tready) begin
      idx_nxt   = idx_r + IDX_W'(1);
      group_nxt = {group_r[GROUP_W-BYTE_W-1:0], BYTE_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    group_r <= group_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_tready && !out_tlast) |=>
      (busy_r && idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("byte index did not advance");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("byte index out of range");

endmodule

### design/enc_8b10b_packer.sv
// Top level of the 8b/10b encoder with a 40-bit byte packer.
//
// Input channel in_*: one data byte per request in in_tdata, with in_tuser
// set to start a new frame (disparity goes negative, held symbols drop).
// Output channel out_*: bytes of each 40-bit group of four symbols, most
// significant first; out_tlast marks the fifth byte of a group.
// The bytes of a group pass from the packer through the group queue into
// the serializer register, then leave one per cycle while out_tready is high.
// Throughput: one input byte per cycle while the two-entry group queue has
// room; sustained, four input bytes per five output cycles while out_tready
// is high, set by the single-byte output port of the serializer.
// Reset: rst_n low at a clock edge clears disparity, the packer, the queue
// and the serializer; no byte is presented after reset until four inputs.
// When the receiver stalls, the current byte holds, the queue fills, and
// in_tready falls only once two full groups wait behind the one in flight.
module enc_8b10b_packer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] frame_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] packed_byte
  output logic       out_tlast
);
  import e8b10b_pkg::*;

  logic   f_valid, f_ready;
  group_t f_data;
  logic   b_valid, b_ready;
  group_t b_data;

  e8b10b_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .grp_valid (f_valid),
    .grp_ready (f_ready),
    .grp_data  (f_data)
  );

  e8b10b_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  e8b10b_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_data     (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/tb_enc_8b10b_packer.sv
// Self-checking testbench for the 8b/10b encoder and 40-bit byte packer.
`timescale 1ns / 100ps

class packer_scoreboard;
  localparam logic [4:0] X_D7  = 5'd7;
  localparam logic [4:0] X_D11 = 5'd11;
  localparam logic [4:0] X_D13 = 5'd13;
  localparam logic [4:0] X_D14 = 5'd14;
  localparam logic [4:0] X_D17 = 5'd17;
  localparam logic [4:0] X_D18 = 5'd18;
  localparam logic [4:0] X_D20 = 5'd20;
  localparam logic [3:0] Y_D3  = 4'd3;
  localparam logic [3:0] Y_P7  = 4'd7;
  localparam logic [3:0] Y_A7  = 4'd8;
  localparam int         SYMS_PER_GROUP = 4;
  localparam int         BYTES_PER_GROUP = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  bit           disparity_pos;
  logic [29:0]  held_syms;
  int unsigned  held_count;
  beat_t        expected_beats[$];
  int unsigned  errors;

  function logic [5:0] six_code(input logic [4:0] x);
    logic [5:0] c;
    case (x)
      5'd0:  c = 6'b100111;  5'd1:  c = 6'b011101;  5'd2:  c = 6'b101101;
      5'd3:  c = 6'b110001;  5'd4:  c = 6'b110101;  5'd5:  c = 6'b101001;
      5'd6:  c = 6'b011001;  5'd7:  c = 6'b111000;  5'd8:  c = 6'b111001;
      5'd9:  c = 6'b100101;  5'd10: c = 6'b010101;  5'd11: c = 6'b110100;
      5'd12: c = 6'b001101;  5'd13: c = 6'b101100;  5'd14: c = 6'b011100;
      5'd15: c = 6'b010111;  5'd16: c = 6'b011011;  5'd17: c = 6'b100011;
      5'd18: c = 6'b010011;  5'd19: c = 6'b110010;  5'd20: c = 6'b001011;
      5'd21: c = 6'b101010;  5'd22: c = 6'b011010;  5'd23: c = 6'b111010;
      5'd24: c = 6'b110011;  5'd25: c = 6'b100110;  5'd26: c = 6'b010110;
      5'd27: c = 6'b110110;  5'd28: c = 6'b001110;  5'd29: c = 6'b101110;
      5'd30: c = 6'b011110;  default: c = 6'b101011;
    endcase
    return c;
  endfunction

  function logic [3:0] four_code(input logic [3:0] y);
    logic [3:0] c;
    case (y)
      4'd0: c = 4'b1011;  4'd1: c = 4'b1001;  4'd2: c = 4'b0101;
      4'd3: c = 4'b1100;  4'd4: c = 4'b1101;  4'd5: c = 4'b1010;
      4'd6: c = 4'b0110;  4'd7: c = 4'b1110;  default: c = 4'b0111;
    endcase
    return c;
  endfunction

  function bit next_disparity(input bit rd, input int ones, input int width);
    if (2 * ones > width) return 1'b1;
    if (2 * ones < width) return 1'b0;
    return rd;
  endfunction

  function logic [9:0] encode_byte(input logic [7:0] b);
    logic [4:0] x;
    logic [3:0] y;
    logic [5:0] six;
    logic [3:0] four;
    bit         rd;
    x   = b[4:0];
    y   = {1'b0, b[7:5]};
    rd  = disparity_pos;
    six = six_code(x);
    if (rd && ($countones(six) != 3 || x == X_D7)) six = ~six;
    rd = next_disparity(rd, $countones(six), 6);
    if (y == Y_P7 && ((!rd && (x == X_D17 || x == X_D18 || x == X_D20)) ||
                      (rd && (x == X_D11 || x == X_D13 || x == X_D14)))) begin
      y = Y_A7;
    end
    four = four_code(y);
    if (rd && ($countones(four) != 2 || y == Y_D3)) four = ~four;
    rd = next_disparity(rd, $countones(four), 4);
    disparity_pos = rd;
    return {six, four};
  endfunction

  function void note_request(input logic [7:0] d, input logic frame_start);
    logic [9:0]  sym;
    logic [39:0] group;
    beat_t       beat;
    int          k;
    if (frame_start) begin
      disparity_pos = 1'b0;
      held_syms     = '0;
      held_count    = 0;
    end
    sym = encode_byte(d);
    if (held_count < SYMS_PER_GROUP - 1) begin
      held_syms  = {held_syms[19:0], sym};
      held_count = held_count + 1;
    end else begin
      group = {held_syms, sym};
      for (k = 0; k < BYTES_PER_GROUP; k++) begin
        beat.data = group[39 - 8 * k -: 8];
        beat.last = (k == BYTES_PER_GROUP - 1);
        expected_beats = {expected_beats, beat};
      end
      held_syms  = '0;
      held_count = 0;
    end
  endfunction

  function void check_byte(input logic [7:0] d, input logic last);
    beat_t want;
    if (expected_beats.size() == 0) begin
      errors = errors + 1;
      $display("%0t: unexpected byte: expected none, actual data %h last %b",
               $time, d, last);
      return;
    end
    want = expected_beats.pop_front();
    if (want.data !== d) begin
      errors = errors + 1;
      $display("%0t: packed byte mismatch: expected %h, actual %h",
               $time, want.data, d);
    end
    if (want.last !== last) begin
      errors = errors + 1;
      $display("%0t: group last mismatch: expected %b, actual %b",
               $time, want.last, last);
    end
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction
endclass

module tb_enc_8b10b_packer;
  import e8b10b_pkg::*;

  localparam int DIRECTED_N    = 22;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic [0:0] in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned idle_count = 0;

  packer_scoreboard sb;

  // {frame_start, data_byte}
  logic [8:0] directed_list [DIRECTED_N] = '{
    {1'b1, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h07}, {1'b0, 8'h63},
    {1'b1, 8'hF1}, {1'b1, 8'hF2}, {1'b1, 8'hF4},
    {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
    {1'b1, 8'h20}, {1'b0, 8'hEB}, {1'b0, 8'h20}, {1'b0, 8'hED},
    {1'b1, 8'h20}, {1'b0, 8'hEE}, {1'b0, 8'hFF}, {1'b0, 8'hE7},
    {1'b1, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'h80}, {1'b0, 8'h01}
  };

  enc_8b10b_packer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tuser   (in_tuser),   // [0] frame_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] packed_byte
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] pick_byte();
    logic [4:0] x;
    case ($urandom_range(0, 9))
      0: x = X_D07;
      1: x = X_D11;
      2: x = X_D13;
      3: x = X_D14;
      4: x = X_D17;
      5: x = X_D18;
      6: x = X_D20;
      default: return 8'($urandom_range(0, 255));
    endcase
    return {($urandom_range(0, 1) == 0) ? 3'd7 : 3'd3, x};
  endfunction

  task automatic send_request(input logic [7:0] d, input logic fs, input bit allow_gap);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    sb.note_request(d, fs);
    gap = (allow_gap && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count, input bit allow_gap);
    int n;
    for (n = 0; n < count; n++) begin
      send_request(pick_byte(), $urandom_range(0, 15) == 0, allow_gap);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random back-pressure, one long hold on request
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_byte(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int n;
    sb = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_N; n++) begin
      send_request(directed_list[n][7:0], directed_list[n][8], 1'b1);
    end
    send_random(140, 1'b1);

    // hold the receiver while the sender keeps pushing
    hold_req = 1'b1;
    send_random(60, 1'b0);
    wait_drained();

    send_random(90, 1'b1);
    calm = 1'b1;
    send_random(60, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### enc_8b10b_packer.f
design/e8b10b_pkg.sv
design/e8b10b_front.sv
design/e8b10b_fifo.sv
design/e8b10b_back.sv
design/enc_8b10b_packer.sv
verif/tb_enc_8b10b_packer.sv
